[hdl/tape_machine_command_executor_top_macros.svh]
// assertion macros for the checker file
// no dependencies
`ifndef TAPE_MACHINE_COMMAND_EXECUTOR_TOP_MACROS_SVH
`define TAPE_MACHINE_COMMAND_EXECUTOR_TOP_MACROS_SVH

// property checked outside reset
`define TME_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property that also holds across reset
`define TME_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/tme_pkg.sv]
// shared types and constants of the tape machine command executor
// no dependencies
package tme_pkg;

  localparam int TAPE_DEPTH = 32768;  // power of two, address wraps by truncation
  localparam int ADDR_W     = $clog2(TAPE_DEPTH);
  localparam int CELL_W     = 8;
  localparam int FIELD_W    = 16;
  localparam int TARGET_W   = 15;
  localparam int SUM_W      = FIELD_W + 1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CELL_W-1:0] cell_t;

  typedef enum logic [2:0] {
    CMD_DELTA  = 3'd0,
    CMD_ADDMUL = 3'd1,
    CMD_SET    = 3'd2,
    CMD_SHIFT  = 3'd3,
    CMD_LBEGIN = 3'd4,
    CMD_LEND   = 3'd5,
    CMD_RDBYTE = 3'd6,
    CMD_WRBYTE = 3'd7
  } cmd_t;

  // item waiting for its tape read data
  typedef struct packed {
    logic                valid;
    cmd_t                cmd;
    logic [TARGET_W-1:0] val;
    cell_t               in_byte;
    logic                in_eof;
    addr_t               addr_cur;
    addr_t               addr_off;
  } exec_item_t;

endpackage

[hdl/tme_ram.sv]
// generic ram, one write port and two registered read ports
// no dependencies
module tme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[hdl/tme_front.sv]
// front end: tape clearing sweep, cell pointer, item accept and read issue
// depends on tme_pkg
module tme_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   cmd,
  input  logic signed [15:0]           offset,
  input  logic signed [15:0]           value,
  input  logic [7:0]                   in_byte,
  input  logic                         in_eof,
  input  logic                         exec_adv,
  output tme_pkg::exec_item_t          exec_item,
  output tme_pkg::addr_t               rd_addr_a,
  output tme_pkg::addr_t               rd_addr_b,
  output logic                         clr_we,
  output tme_pkg::addr_t               clr_addr
);
  import tme_pkg::*;

  logic               clr_busy;
  addr_t              ptr;
  addr_t              ptr_next;
  addr_t              off_addr;
  logic [SUM_W-1:0]   off_sum;
  logic [SUM_W-1:0]   move_sum;
  logic               accept;

  assign in_ready = !clr_busy && (!exec_item.valid || exec_adv);
  assign accept   = in_valid && in_ready;
  assign clr_we   = clr_busy;

  assign off_sum  = SUM_W'(ptr) + SUM_W'(offset);
  assign move_sum = SUM_W'(ptr) + SUM_W'(value);
  assign off_addr = off_sum[ADDR_W-1:0];

  always_comb begin
    ptr_next = ptr;
    if (accept && cmd_t'(cmd) == CMD_SHIFT) begin
      ptr_next = move_sum[ADDR_W-1:0];
    end
  end

  // while nothing new enters, keep reading the waiting item's cells
  assign rd_addr_a = accept ? ptr      : exec_item.addr_cur;
  assign rd_addr_b = accept ? off_addr : exec_item.addr_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy        <= 1'b1;
      clr_addr        <= '0;
      ptr             <= '0;
      exec_item.valid <= 1'b0;
    end else begin
      if (clr_busy) begin
        clr_addr <= clr_addr + addr_t'(1);
        if (clr_addr == addr_t'(TAPE_DEPTH - 1)) begin
          clr_busy <= 1'b0;
        end
      end
      ptr <= ptr_next;
      if (accept) begin
        exec_item.valid <= 1'b1;
      end else if (exec_adv) begin
        exec_item.valid <= 1'b0;
      end
    end
    if (accept) begin
      exec_item.cmd      <= cmd_t'(cmd);
      exec_item.val      <= value[TARGET_W-1:0];
      exec_item.in_byte  <= in_byte;
      exec_item.in_eof   <= in_eof;
      exec_item.addr_cur <= ptr;
      exec_item.addr_off <= off_addr;
    end
  end

endmodule

[hdl/tme_back.sv]
// back end: cell update with write forwarding, result register
// depends on tme_pkg
module tme_back (
  input  logic                         clk,
  input  logic                         rst,
  input  tme_pkg::exec_item_t          exec_item,
  input  tme_pkg::cell_t               rdata_a,
  input  tme_pkg::cell_t               rdata_b,
  input  tme_pkg::addr_t               rd_addr_a,
  input  tme_pkg::addr_t               rd_addr_b,
  output logic                         exec_adv,
  output logic                         wr_en,
  output tme_pkg::addr_t               wr_addr,
  output tme_pkg::cell_t               wr_data,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic                         out_valid,
  output logic [7:0]                   out_byte,
  output logic                         jump_taken,
  output logic [14:0]                  jump_target
);
  import tme_pkg::*;

  logic                        fwd_a;
  logic                        fwd_b;
  cell_t                       fwd_data;
  cell_t                       cur;
  cell_t                       tgt;
  logic [2*CELL_W-1:0]         prod;
  logic                        ov_next;
  cell_t                       ob_next;
  logic                        jt_next;
  logic [TARGET_W-1:0]         tg_next;

  assign exec_adv = exec_item.valid && (!res_valid || res_ready);

  // last cycle's write has not reached the ram read data yet
  assign cur  = fwd_a ? fwd_data : rdata_a;
  assign tgt  = fwd_b ? fwd_data : rdata_b;
  assign prod = cur * exec_item.val[CELL_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = exec_item.addr_cur;
    wr_data = '0;
    ov_next = 1'b0;
    ob_next = '0;
    jt_next = 1'b0;
    tg_next = '0;
    unique case (exec_item.cmd)
      CMD_DELTA: begin
        wr_en   = exec_adv;
        wr_addr = exec_item.addr_off;
        wr_data = tgt + exec_item.val[CELL_W-1:0];
      end
      CMD_ADDMUL: begin
        wr_en   = exec_adv;
        wr_addr = exec_item.addr_off;
        wr_data = tgt + prod[CELL_W-1:0];
      end
      CMD_SET: begin
        wr_en   = exec_adv;
        wr_data = exec_item.val[CELL_W-1:0];
      end
      CMD_SHIFT: begin
      end
      CMD_LBEGIN: begin
        if (cur == '0) begin
          jt_next = 1'b1;
          tg_next = exec_item.val;
        end
      end
      CMD_LEND: begin
        if (cur != '0) begin
          jt_next = 1'b1;
          tg_next = exec_item.val;
        end
      end
      CMD_RDBYTE: begin
        wr_en   = exec_adv;
        wr_data = exec_item.in_eof ? '0 : exec_item.in_byte;
      end
      CMD_WRBYTE: begin
        ov_next = 1'b1;
        ob_next = cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_a     <= 1'b0;
      fwd_b     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      fwd_a <= wr_en && (rd_addr_a == wr_addr);
      fwd_b <= wr_en && (rd_addr_b == wr_addr);
      if (exec_adv) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
    fwd_data <= wr_data;
    if (exec_adv) begin
      out_valid   <= ov_next;
      out_byte    <= ob_next;
      jump_taken  <= jt_next;
      jump_target <= tg_next;
    end
  end

endmodule

[hdl/tape_machine_command_executor_top.sv]
// top level of the tape machine command executor
// depends on tme_pkg, tme_ram, tme_front, tme_back
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  command | in_valid / in_ready  | cmd, offset, value, in_byte, in_eof
//  result  | res_valid / res_ready| out_valid, out_byte, jump_taken, jump_target
//
// one item per cycle while results are taken; an accepted item waits in the item register,
// reading the current cell and the offset cell on the two ram read ports, then moves on to
// the result register, updating at most one cell through the single write port
// after reset a clearing pass zeroes all 32768 cells of the tape, with in_ready low
// a stalled result holds one item in the result register and one waiting on its read data
module tape_machine_command_executor_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         cmd,
  input  logic signed [15:0] offset,
  input  logic signed [15:0] value,
  input  logic [7:0]         in_byte,
  input  logic               in_eof,
  output logic               res_valid,
  input  logic               res_ready,
  output logic               out_valid,
  output logic [7:0]         out_byte,
  output logic               jump_taken,
  output logic [14:0]        jump_target
);
  import tme_pkg::*;

  exec_item_t exec_item;
  logic       exec_adv;
  addr_t      rd_addr_a;
  addr_t      rd_addr_b;
  cell_t      rdata_a;
  cell_t      rdata_b;
  logic       clr_we;
  addr_t      clr_addr;
  logic       ex_we;
  addr_t      ex_waddr;
  cell_t      ex_wdata;
  logic       ram_we;
  addr_t      ram_waddr;
  cell_t      ram_wdata;

  // the clearing pass owns the write port; no item is in flight then
  assign ram_we    = clr_we || ex_we;
  assign ram_waddr = clr_we ? clr_addr : ex_waddr;
  assign ram_wdata = clr_we ? '0 : ex_wdata;

  tme_ram #(
    .WIDTH (CELL_W),
    .DEPTH (TAPE_DEPTH)
  ) u_tape (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  tme_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .offset    (offset),
    .value     (value),
    .in_byte   (in_byte),
    .in_eof    (in_eof),
    .exec_adv  (exec_adv),
    .exec_item (exec_item),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .clr_we    (clr_we),
    .clr_addr  (clr_addr)
  );

  tme_back u_back (
    .clk         (clk),
    .rst         (rst),
    .exec_item   (exec_item),
    .rdata_a     (rdata_a),
    .rdata_b     (rdata_b),
    .rd_addr_a   (rd_addr_a),
    .rd_addr_b   (rd_addr_b),
    .exec_adv    (exec_adv),
    .wr_en       (ex_we),
    .wr_addr     (ex_waddr),
    .wr_data     (ex_wdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .jump_taken  (jump_taken),
    .jump_target (jump_target)
  );

endmodule

[hdl/tme_checker.sv]
// port-level checks of the tape machine command executor, bound to the top level
// depends on tape_machine_command_executor_top_macros.svh
`include "tape_machine_command_executor_top_macros.svh"

module tme_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [2:0]         cmd,
  input logic signed [15:0] offset,
  input logic signed [15:0] value,
  input logic [7:0]         in_byte,
  input logic               in_eof,
  input logic               res_valid,
  input logic               res_ready,
  input logic               out_valid,
  input logic [7:0]         out_byte,
  input logic               jump_taken,
  input logic [14:0]        jump_target
);

  logic        res_stall;
  logic [24:0] res_fields;
  logic        unused_zero;

  assign res_stall   = res_valid && !res_ready;
  assign res_fields  = {out_valid, out_byte, jump_taken, jump_target};
  assign unused_zero = (jump_taken || jump_target == 15'd0) && (out_valid || out_byte == 8'd0);

  // tape clearing starts right after reset, nothing enters or leaves
  `TME_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !in_ready && !res_valid, "busy after reset")

  // a stalled result keeps its fields
  `TME_ASSERT(a_hold, clk, rst, res_stall |=> res_valid && $stable(res_fields), "result changed")

  // an output byte and a jump never come from the same item
  `TME_ASSERT(a_res_excl, clk, rst, res_valid |-> !(out_valid && jump_taken), "byte and jump")

  // fields that do not apply stay zero
  `TME_ASSERT(a_res_zero, clk, rst, res_valid |-> unused_zero, "unused result field not zero")

endmodule

bind tape_machine_command_executor_top tme_checker u_tme_checker (.*);
